// ===== rtl/core/msaa_pkg.sv =====
// Shared types and constants for the mesh surface area accumulator.
// No dependencies.
`default_nettype none
package msaa_pkg;
   localparam int CoordWidth = 16;
   localparam int EdgeWidth  = 17;
   localparam int CrossWidth = 35;
   localparam int SqWidth    = 72;
   localparam int RootWidth  = 36;
   localparam int SumWidth   = 48;
   localparam int CountWidth = 13;
   localparam int IndexWidth = 16;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic start;
      logic [SqWidth-1:0] radicand;
   } root_req_type;

   typedef struct packed {
      logic done;
      logic busy;
      logic [RootWidth-1:0] root;
   } root_rsp_type;
endpackage
`default_nettype wire

// ===== rtl/core/msaa_isqrt.sv =====
// Digit-by-digit floor square root of a 72-bit radicand, one result bit a cycle.
// Depends on msaa_pkg.
`default_nettype none
module msaa_isqrt import msaa_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire root_req_type req,
   output root_rsp_type      rsp
);
   localparam int StepWidth = 6;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [StepWidth-1:0]   step_ff, step_in;
   logic [SqWidth-1:0]     rem_ff, rem_in;
   logic [RootWidth-1:0]   root_ff, root_in;
   logic [SqWidth-1:0]     num_ff, num_in;

   logic [RootWidth+1:0]   trial;
   logic [RootWidth+1:0]   part;
   logic [SqWidth-1:0]     rem_shift;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      num_in  = num_ff;
      // Bring down two radicand bits, try root*4+1.
      rem_shift = {rem_ff[SqWidth-3:0], num_ff[SqWidth-1 -: 2]};
      trial     = {root_ff, 2'b01};
      part      = rem_shift[RootWidth+1:0];
      if (req.start) begin
         busy_in = 1'b1;
         step_in = StepWidth'(RootWidth - 1);
         rem_in  = '0;
         root_in = '0;
         num_in  = req.radicand;
      end else if (busy_ff) begin
         num_in = {num_ff[SqWidth-3:0], 2'b00};
         if (rem_shift[SqWidth-1:RootWidth+2] != '0 || part >= trial) begin
            rem_in  = rem_shift - SqWidth'(trial);
            root_in = {root_ff[RootWidth-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[RootWidth-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      num_ff  <= num_in;
   end

   assign rsp.done = done_ff;
   assign rsp.busy = busy_ff;
   assign rsp.root = root_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("root done without a run");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.start)
      else $error("root restarted while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("root done held");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/mesh_surface_area_accumulator_unit.sv =====
// Write/clear/unused, and an add with a bad index, go from decode to output.
// Add runs decode, 3 vertex reads, edges, 7 multiply steps, 7 squaring steps,
// square root, sum, output. One item in flight; the next request is taken
// once the last leaves output. Bit-serial square root; one shared 17x17 cross
// product multiplier. A held result stalls only the output step.
// Reset (synchronous, active high) clears area sum, flag, vertex_count, control.
// Vertex store contents are undefined until written.
`default_nettype none
module mesh_surface_area_accumulator_unit import msaa_pkg::*; #(
   parameter int VERTEX_DEPTH = 4096
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_enable,
   input  wire logic [CountWidth-1:0]        csr_write_data,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [1:0]                   req_cmd,
   input  wire logic [IndexWidth-1:0]        req_index_a,
   input  wire logic [IndexWidth-1:0]        req_index_b,
   input  wire logic [IndexWidth-1:0]        req_index_c,
   input  wire logic signed [CoordWidth-1:0] req_pos_x,
   input  wire logic signed [CoordWidth-1:0] req_pos_y,
   input  wire logic signed [CoordWidth-1:0] req_pos_z,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [RootWidth-1:0]              rsp_triangle_area,
   output logic [SumWidth-1:0]               rsp_area_total,
   output logic                              rsp_skipped,
   output logic                              rsp_saturated
);
   localparam int AddrWidth = $clog2(VERTEX_DEPTH);
   localparam int VtxWidth  = 3 * CoordWidth;
   localparam logic [SumWidth-1:0] SumMax = '1;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_DEC   = 11'b00000000010,
      ST_RD_A  = 11'b00000000100,
      ST_RD_B  = 11'b00000001000,
      ST_RD_C  = 11'b00000010000,
      ST_EDGE  = 11'b00000100000,
      ST_MUL   = 11'b00001000000,
      ST_SQ    = 11'b00010000000,
      ST_ROOT  = 11'b00100000000,
      ST_SUM   = 11'b01000000000,
      ST_OUT   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [VtxWidth-1:0]   mem [VERTEX_DEPTH];
   logic [VtxWidth-1:0]   rd_data_ff;
   logic [AddrWidth-1:0]  rd_addr;

   logic [CountWidth-1:0] vcount_ff;
   logic [SumWidth-1:0]   sum_ff, sum_in;
   logic                  sat_ff, sat_in;

   cmd_type               cmd_ff;
   logic [IndexWidth-1:0] ia_ff, ib_ff, ic_ff;
   logic [VtxWidth-1:0]   va_ff, vb_ff;
   logic signed [EdgeWidth-1:0] e1_ff [3];
   logic signed [EdgeWidth-1:0] e2_ff [3];
   logic signed [CrossWidth-1:0] cr_ff [3];
   logic [SqWidth-1:0]    sq_ff;
   logic [2:0]            step_ff;
   logic signed [2*EdgeWidth-1:0] prod_ff;
   logic [RootWidth-1:0]  area_ff;
   logic                  skip_ff;
   logic                  rsp_valid_ff;

   root_req_type          rreq;
   root_rsp_type          rrsp;

   msaa_isqrt u_isqrt (.clock(clock), .reset(reset), .req(rreq), .rsp(rrsp));

   function automatic logic idx_ok(input logic [IndexWidth-1:0] idx,
                                   input logic [CountWidth-1:0] cnt);
      return ({1'b0, idx} < {4'b0, cnt}) && ({1'b0, idx} < 17'(VERTEX_DEPTH));
   endfunction

   function automatic logic signed [CoordWidth-1:0] crd(input logic [VtxWidth-1:0] v,
                                                        input int ax);
      return v[ax*CoordWidth +: CoordWidth];
   endfunction

   // Shared multiplier operands: steps 0..5 cross terms; the 3 squares of
   // cross components are done apart, as 35-bit magnitude split in ST_SQ.
   logic signed [EdgeWidth-1:0] mul_a, mul_b;
   always_comb begin
      mul_a = e1_ff[1]; mul_b = e2_ff[2];
      case (step_ff)
         3'd0: begin mul_a = e1_ff[1]; mul_b = e2_ff[2]; end
         3'd1: begin mul_a = e1_ff[2]; mul_b = e2_ff[1]; end
         3'd2: begin mul_a = e1_ff[2]; mul_b = e2_ff[0]; end
         3'd3: begin mul_a = e1_ff[0]; mul_b = e2_ff[2]; end
         3'd4: begin mul_a = e1_ff[0]; mul_b = e2_ff[1]; end
         3'd5: begin mul_a = e1_ff[1]; mul_b = e2_ff[0]; end
         default: begin mul_a = e1_ff[0]; mul_b = e2_ff[0]; end
      endcase
   end

   logic signed [2*EdgeWidth-1:0] prod;
   assign prod = mul_a * mul_b;

   // Squaring: magnitude of the cross component, 35x35 cut into hi/lo parts,
   // h^2, l^2 registered first: m = h*2^18 + l; m^2 = h^2*2^36 + 2hl*2^18 + l^2.
   logic signed [CrossWidth-1:0] cr_sel;
   logic [CrossWidth-1:0] mag;
   logic [1:0]            sqi_ff;
   logic                  sqph_ff;
   logic [33:0]           sq_p0_ff;
   logic [35:0]           sq_p1_ff;
   logic [16:0]           mh;
   logic [17:0]           ml;
   logic [33:0]           hh;
   logic [35:0]           ll;
   logic [34:0]           hl;
   always_comb begin
      case (sqi_ff)
         2'd1: cr_sel = cr_ff[1];
         2'd2: cr_sel = cr_ff[2];
         default: cr_sel = cr_ff[0];
      endcase
      mag = cr_sel[CrossWidth-1] ? CrossWidth'(-cr_sel) : CrossWidth'(cr_sel);
      mh  = mag[CrossWidth-1:18];
      ml  = mag[17:0];
      hh  = mh * mh;
      ll  = ml * ml;
      hl  = mh * ml;
   end

   logic [SumWidth:0] sum_try;
   always_comb sum_try = {1'b0, sum_ff} + {13'b0, area_ff};

   always_comb rd_addr = (state_ff == ST_RD_A) ? ia_ff[AddrWidth-1:0] :
                         (state_ff == ST_RD_B) ? ib_ff[AddrWidth-1:0] :
                                                 ic_ff[AddrWidth-1:0];

   assign req_ready = (state_ff == ST_IDLE);
   assign rreq.start    = (state_ff == ST_SQ) && sqi_ff == 2'd3;
   assign rreq.radicand = sq_ff;

   always_comb begin
      state_in = state_ff;
      sum_in   = sum_ff;
      sat_in   = sat_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_DEC;
         ST_DEC: begin
            case (cmd_ff)
               CMD_ADD: state_in = skip_ff ? ST_OUT : ST_RD_A;
               CMD_CLEAR: begin
                  sum_in = '0; sat_in = 1'b0; state_in = ST_OUT;
               end
               default: state_in = ST_OUT;
            endcase
         end
         ST_RD_A: state_in = ST_RD_B;
         ST_RD_B: state_in = ST_RD_C;
         ST_RD_C: state_in = ST_EDGE;
         ST_EDGE: state_in = ST_MUL;
         ST_MUL:  if (step_ff == 3'd6) state_in = ST_SQ;
         ST_SQ:   if (sqi_ff == 2'd3) state_in = ST_ROOT;
         ST_ROOT: if (rrsp.done) state_in = ST_SUM;
         ST_SUM: begin
            if (sum_try[SumWidth]) begin
               sum_in = SumMax; sat_in = 1'b1;
            end else begin
               sum_in = sum_try[SumWidth-1:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= '0;
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         sat_ff   <= sat_in;
         if (csr_write_enable) vcount_ff <= csr_write_data;
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Vertex store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (state_ff == ST_DEC && cmd_ff == CMD_WRITE &&
          {1'b0, ia_ff} < 17'(VERTEX_DEPTH))
         mem[ia_ff[AddrWidth-1:0]] <= {va_ff};
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         cmd_ff  <= cmd_type'(req_cmd);
         ia_ff   <= req_index_a;
         ib_ff   <= req_index_b;
         ic_ff   <= req_index_c;
         va_ff   <= {req_pos_z, req_pos_y, req_pos_x};
         area_ff <= '0;
         skip_ff <= (cmd_type'(req_cmd) == CMD_ADD) &&
                    !(idx_ok(req_index_a, vcount_ff) && idx_ok(req_index_b, vcount_ff) &&
                      idx_ok(req_index_c, vcount_ff));
      end
      // Read data is registered and lands in the state after its address state.
      if (state_ff == ST_RD_B) va_ff <= rd_data_ff;
      if (state_ff == ST_RD_C) vb_ff <= rd_data_ff;
      if (state_ff == ST_EDGE) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= EdgeWidth'(crd(vb_ff, i)) - EdgeWidth'(crd(va_ff, i));
            e2_ff[i] <= EdgeWidth'(crd(rd_data_ff, i)) - EdgeWidth'(crd(va_ff, i));
         end
         step_ff <= '0;
         sqi_ff  <= '0;
         sqph_ff <= 1'b0;
         sq_ff   <= '0;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= prod;
         step_ff <= step_ff + 1'b1;
         // Odd step finishes a component: first product minus second.
         if (step_ff[0])
            cr_ff[step_ff[2:1]] <= CrossWidth'(prod_ff) - CrossWidth'(prod);
      end
      if (state_ff == ST_SQ && sqi_ff != 2'd3) begin
         if (!sqph_ff) begin
            sq_p0_ff <= hh;
            sq_p1_ff <= ll;
            sqph_ff  <= 1'b1;
         end else begin
            sq_ff <= sq_ff + {2'b0, sq_p0_ff, 36'b0} + {36'b0, sq_p1_ff}
                   + {18'b0, hl, 19'b0};
            sqph_ff <= 1'b0;
            sqi_ff  <= sqi_ff + 1'b1;
         end
      end
      if (state_ff == ST_ROOT && rrsp.done) area_ff <= rrsp.root;
   end

   assign rsp_valid         = rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_triangle_area <= area_ff;
         rsp_area_total    <= sum_ff;
         rsp_skipped       <= skip_ff;
         rsp_saturated     <= sat_ff;
      end
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a beat while busy");
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> (sum_ff == SumMax || $past(cmd_ff) == CMD_CLEAR || !$past(sat_ff)))
      else $error("saturated but sum below maximum");
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_skipped) |-> rsp_triangle_area == '0)
      else $error("skipped triangle with area");
   a_root_in_step: assert property (@(posedge clock) disable iff (reset)
      rrsp.busy |-> state_ff == ST_ROOT)
      else $error("root running outside its step");
`endif
endmodule
`default_nettype wire

// ===== test/msaa_checker.sv =====
// Scoreboard for the mesh surface area accumulator: watches the request, result
// and CSR ports, predicts each result beat and compares it. Depends on msaa_pkg.
`timescale 1ns / 100ps
module msaa_checker import msaa_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_enable,
   input  wire logic [CountWidth-1:0]        csr_write_data,
   input  wire logic                         req_valid,
   input  wire logic                         req_ready,
   input  wire logic [1:0]                   req_cmd,
   input  wire logic [IndexWidth-1:0]        req_index_a,
   input  wire logic [IndexWidth-1:0]        req_index_b,
   input  wire logic [IndexWidth-1:0]        req_index_c,
   input  wire logic signed [CoordWidth-1:0] req_pos_x,
   input  wire logic signed [CoordWidth-1:0] req_pos_y,
   input  wire logic signed [CoordWidth-1:0] req_pos_z,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   input  wire logic [RootWidth-1:0]         rsp_triangle_area,
   input  wire logic [SumWidth-1:0]          rsp_area_total,
   input  wire logic                         rsp_skipped,
   input  wire logic                         rsp_saturated,
   output int                                fail_count
);
   localparam int StoreDepth = 4096;
   localparam int StoreAddrWidth = 12;
   localparam logic [SumWidth-1:0] SumMax = '1;

   typedef struct {
      logic [RootWidth-1:0] area;
      logic [SumWidth-1:0]  total;
      logic                 skipped;
      logic                 saturated;
   } area_result_type;

   logic [47:0]           vertex_mem [StoreDepth];
   logic [SumWidth-1:0]   running_sum;
   logic                  sum_clipped;
   logic [CountWidth-1:0] vertex_limit;
   area_result_type       pending_areas [$];

   function automatic logic [RootWidth-1:0] floor_root(logic [SqWidth-1:0] n);
      logic [SqWidth-1:0] r;
      logic [SqWidth-1:0] t;
      r = '0;
      for (int b = RootWidth - 1; b >= 0; b--) begin
         t = r | (72'd1 << b);
         if (t * t <= n) r = t;
      end
      return r[RootWidth-1:0];
   endfunction

   function automatic longint axis(logic [47:0] v, int k);
      return longint'($signed(v[16*k +: 16]));
   endfunction

   function automatic logic [RootWidth-1:0] tri_area(logic [47:0] va, logic [47:0] vb,
                                                     logic [47:0] vc);
      longint e1 [3];
      longint e2 [3];
      longint cr [3];
      logic [SqWidth-1:0] acc;
      logic [SqWidth-1:0] m;
      for (int k = 0; k < 3; k++) begin
         e1[k] = axis(vb, k) - axis(va, k);
         e2[k] = axis(vc, k) - axis(va, k);
      end
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      acc = '0;
      for (int k = 0; k < 3; k++) begin
         m = (cr[k] < 0) ? SqWidth'(-cr[k]) : SqWidth'(cr[k]);
         acc = acc + m * m;
      end
      return floor_root(acc);
   endfunction

   function automatic logic index_valid(logic [IndexWidth-1:0] idx);
      return (idx < vertex_limit) && (idx < StoreDepth);
   endfunction

   always @(posedge clock) begin
      area_result_type nx;
      area_result_type got;
      area_result_type want;
      if (reset) begin
         running_sum  = '0;
         sum_clipped  = 1'b0;
         vertex_limit = '0;
         pending_areas.delete();
         fail_count   = 0;
      end else begin
         if (csr_write_enable) vertex_limit = csr_write_data;
         if (req_valid && req_ready) begin
            nx.area    = '0;
            nx.skipped = 1'b0;
            case (cmd_type'(req_cmd))
               CMD_WRITE: begin
                  if (req_index_a < StoreDepth)
                     vertex_mem[req_index_a[StoreAddrWidth-1:0]] =
                        {req_pos_z, req_pos_y, req_pos_x};
               end
               CMD_ADD: begin
                  if (index_valid(req_index_a) && index_valid(req_index_b) &&
                      index_valid(req_index_c)) begin
                     nx.area = tri_area(vertex_mem[req_index_a[StoreAddrWidth-1:0]],
                                        vertex_mem[req_index_b[StoreAddrWidth-1:0]],
                                        vertex_mem[req_index_c[StoreAddrWidth-1:0]]);
                     if (SumWidth'(nx.area) > SumMax - running_sum) begin
                        running_sum = SumMax;
                        sum_clipped = 1'b1;
                     end else begin
                        running_sum = running_sum + SumWidth'(nx.area);
                     end
                  end else begin
                     nx.skipped = 1'b1;
                  end
               end
               CMD_CLEAR: begin
                  running_sum = '0;
                  sum_clipped = 1'b0;
               end
               default: ;
            endcase
            nx.total     = running_sum;
            nx.saturated = sum_clipped;
            pending_areas = {pending_areas, nx};
         end
         if (rsp_valid && rsp_ready) begin
            got.area      = rsp_triangle_area;
            got.total     = rsp_area_total;
            got.skipped   = rsp_skipped;
            got.saturated = rsp_saturated;
            if (pending_areas.size() == 0) begin
               $display("%0t: unexpected result beat area=%0d total=%0d",
                        $time, got.area, got.total);
               fail_count++;
            end else begin
               want = pending_areas.pop_front();
               if (got.area !== want.area) begin
                  $display("%0t: triangle_area expected %0d actual %0d",
                           $time, want.area, got.area);
                  fail_count++;
               end
               if (got.total !== want.total) begin
                  $display("%0t: area_total expected %0d actual %0d",
                           $time, want.total, got.total);
                  fail_count++;
               end
               if (got.skipped !== want.skipped) begin
                  $display("%0t: skipped expected %0b actual %0b",
                           $time, want.skipped, got.skipped);
                  fail_count++;
               end
               if (got.saturated !== want.saturated) begin
                  $display("%0t: saturated expected %0b actual %0b",
                           $time, want.saturated, got.saturated);
                  fail_count++;
               end
            end
         end
      end
   end

   // count results still owed so the top can flag leftovers
   function automatic int owed();
      return pending_areas.size();
   endfunction
endmodule

// ===== test/tb_top.sv =====
// Stimulus and verdict for mesh_surface_area_accumulator_unit; the result
// checking lives in msaa_checker. Depends on msaa_pkg and msaa_checker.
`timescale 1ns / 100ps
module tb_top;
   import msaa_pkg::*;

   localparam int StoreDepth = 4096;
   localparam int StallLimit = 20000;

   logic                         clock;
   logic                         reset;
   logic                         csr_write_enable;
   logic [CountWidth-1:0]        csr_write_data;
   logic                         req_valid;
   logic                         req_ready;
   logic [1:0]                   req_cmd;
   logic [IndexWidth-1:0]        req_index_a;
   logic [IndexWidth-1:0]        req_index_b;
   logic [IndexWidth-1:0]        req_index_c;
   logic signed [CoordWidth-1:0] req_pos_x;
   logic signed [CoordWidth-1:0] req_pos_y;
   logic signed [CoordWidth-1:0] req_pos_z;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [RootWidth-1:0]         rsp_triangle_area;
   logic [SumWidth-1:0]          rsp_area_total;
   logic                         rsp_skipped;
   logic                         rsp_saturated;
   int                           fail_count;

   int   beats_sent;
   int   beats_seen;
   int   idle_cycles;
   int   stall_hold;
   logic quiet_mode;
   logic vertex_written [StoreDepth];
   int   cur_limit;

   mesh_surface_area_accumulator_unit #(.VERTEX_DEPTH(StoreDepth)) dut (.*);

   msaa_checker scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver backpressure: mostly ready, short stalls, a few long ones
   always @(posedge clock) begin
      if (reset || quiet_mode) begin
         rsp_ready  <= 1'b1;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         rsp_ready  <= 1'b0;
         stall_hold <= stall_hold - 1;
      end else if ($urandom_range(0, 99) < 80) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready  <= 1'b0;
         stall_hold <= ($urandom_range(0, 99) < 8) ? $urandom_range(20, 80)
                                                  : $urandom_range(0, 2);
      end
   end

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready && !reset) begin
         beats_seen++;
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= StallLimit) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic send_beat(cmd_type c, int ia, int ib, int ic, int x, int y, int z);
      req_valid   <= 1'b1;
      req_cmd     <= c;
      req_index_a <= IndexWidth'(ia);
      req_index_b <= IndexWidth'(ib);
      req_index_c <= IndexWidth'(ic);
      req_pos_x   <= CoordWidth'(x);
      req_pos_y   <= CoordWidth'(y);
      req_pos_z   <= CoordWidth'(z);
      if (c == CMD_WRITE && ia < StoreDepth) vertex_written[ia] = 1'b1;
      beats_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic sender_gap();
      int n;
      n = 0;
      if (!quiet_mode) begin
         case ($urandom_range(0, 19))
            0: n = $urandom_range(20, 100);
            1, 2, 3, 4, 5: n = $urandom_range(1, 4);
            default: n = 0;
         endcase
      end
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_seen != beats_sent) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_vertex_count(int v);
      drain();
      csr_write_data   <= CountWidth'(v);
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_limit = (v < StoreDepth) ? v : StoreDepth;
      @(posedge clock);
   endtask

   function automatic int rand_coord();
      case ($urandom_range(0, 9))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return int'($signed(16'($urandom())));
      endcase
   endfunction

   // pick an index that reads a written vertex, or one that is out of range
   function automatic int pick_index(logic want_bad);
      int i;
      if (!want_bad && cur_limit > 0) begin
         for (int t = 0; t < 30; t++) begin
            i = $urandom_range(0, (cur_limit > 64) ? 63 : cur_limit - 1);
            if ($urandom_range(0, 3) == 0) i = $urandom_range(0, cur_limit - 1);
            if (vertex_written[i]) return i;
         end
      end
      return $urandom_range(cur_limit, 65535);
   endfunction

   task automatic random_phase(int count);
      int r;
      int addr;
      logic bad;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            addr = (cur_limit > 0) ? $urandom_range(0, (cur_limit > 64) ? 63 : cur_limit - 1)
                                   : $urandom_range(0, 63);
            if ($urandom_range(0, 9) < 2) addr = $urandom_range(0, StoreDepth - 1);
            if ($urandom_range(0, 9) == 0) addr = $urandom_range(0, 65535);
            send_beat(CMD_WRITE, addr, $urandom_range(0, 65535), $urandom_range(0, 65535),
                      rand_coord(), rand_coord(), rand_coord());
         end else if (r < 90) begin
            bad = ($urandom_range(0, 9) == 0);
            send_beat(CMD_ADD, pick_index(bad), pick_index(1'b0), pick_index(1'b0),
                      rand_coord(), rand_coord(), rand_coord());
         end else if (r < 95) begin
            send_beat(CMD_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), rand_coord(), rand_coord(), rand_coord());
         end else begin
            send_beat(CMD_NONE, $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), rand_coord(), rand_coord(), rand_coord());
         end
         if ($urandom_range(0, 199) == 0) drain();
         sender_gap();
      end
   endtask

   initial begin
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_valid        <= 1'b0;
      req_cmd          <= CMD_NONE;
      req_index_a      <= '0;
      req_index_b      <= '0;
      req_index_c      <= '0;
      req_pos_x        <= '0;
      req_pos_y        <= '0;
      req_pos_z        <= '0;
      rsp_ready        <= 1'b1;
      beats_sent   = 0;
      beats_seen   = 0;
      idle_cycles  = 0;
      quiet_mode   = 1'b0;
      cur_limit    = 0;
      foreach (vertex_written[i]) vertex_written[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corners of the coordinate cube and small shapes
      set_vertex_count(16);
      send_beat(CMD_WRITE, 0, 65535, 65535, -32768, -32768, -32768);
      send_beat(CMD_WRITE, 1, 0, 0, 32767, 32767, -32768);
      send_beat(CMD_WRITE, 2, 0, 0, 32767, -32768, 32767);
      send_beat(CMD_WRITE, 3, 0, 0, 0, 0, 0);
      send_beat(CMD_WRITE, 4, 0, 0, 16, 0, 0);
      send_beat(CMD_WRITE, 5, 0, 0, 0, 16, 0);
      send_beat(CMD_WRITE, 6, 0, 0, 32767, 32767, 32767);
      send_beat(CMD_WRITE, 4096, 0, 0, 1, 2, 3);
      send_beat(CMD_WRITE, 65535, 0, 0, -1, -1, -1);
      send_beat(CMD_ADD, 0, 1, 2, 0, 0, 0);
      send_beat(CMD_ADD, 3, 4, 5, -32768, 32767, 0);
      send_beat(CMD_ADD, 3, 3, 3, 0, 0, 0);
      send_beat(CMD_ADD, 0, 6, 3, 0, 0, 0);
      send_beat(CMD_ADD, 0, 1, 16, 0, 0, 0);
      send_beat(CMD_ADD, 65535, 0, 1, 0, 0, 0);
      send_beat(CMD_ADD, 2, 65535, 0, 0, 0, 0);
      send_beat(CMD_NONE, 65535, 65535, 65535, -1, -1, -1);
      send_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
      send_beat(CMD_ADD, 2, 1, 0, 0, 0, 0);
      send_beat(CMD_NONE, 0, 0, 0, 0, 0, 0);

      // largest triangles back to back with the receiver always ready
      drain();
      quiet_mode = 1'b1;
      for (int k = 0; k < 24; k++) send_beat(CMD_ADD, 0, 1, 2, 0, 0, 0);
      send_beat(CMD_ADD, 2, 0, 1, 0, 0, 0);
      send_beat(CMD_NONE, 0, 0, 0, 0, 0, 0);
      send_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
      send_beat(CMD_ADD, 3, 4, 5, 0, 0, 0);
      quiet_mode = 1'b0;

      set_vertex_count(4096);
      random_phase(400);
      set_vertex_count(0);
      random_phase(150);
      set_vertex_count(8191);
      random_phase(300);
      set_vertex_count(3);
      quiet_mode = 1'b1;
      random_phase(200);
      quiet_mode = 1'b0;
      set_vertex_count($urandom_range(1, 200));
      random_phase(350);
      set_vertex_count(16);
      random_phase(400);

      drain();
      if (fail_count == 0 && scoreboard.owed() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule
